// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form: when the trigger holds, the consequence must hold.
`define ASSERT_IMPL(label, trig, cons, msg) \
	`ASSERT_CLK(label, (trig) |-> (cons), msg)

`endif

// ===== rtl/cpi_pkg.sv =====
// ----------------------------------------------------------------------------
// cpi_pkg
// Types and constants shared by the cyclic prefix inserter modules.
// ----------------------------------------------------------------------------
package cpi_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SHIFT_W    = 5;
	localparam int CP_LEN_W   = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Longest prefix honored; longer settings saturate here.
	localparam logic [CP_LEN_W-1:0] CP_MAX       = 6'd32;
	localparam logic [CP_LEN_W-1:0] CP_LEN_RESET = 6'd8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CP_LEN           = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST_TAG_ENABLE = 2'd1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_i;
		logic signed [SAMPLE_W-1:0] in_q;
		logic [SHIFT_W-1:0]         delay_shift;
		logic                       more_in_packet;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_i;
		logic signed [SAMPLE_W-1:0] out_q;
		logic                       burst_flag;
		logic                       symbol_end;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr;     // store the accepted sample
		logic start;  // load the playout start index
		logic rd;     // read the next playout sample
		logic burst;  // burst flag for the sample being read
		logic last;   // the sample being read ends the symbol
	} cpi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_issue;  // the read stage can take a new read
	} cpi_status_t;

	function automatic logic [CP_LEN_W-1:0] cp_sat(input logic [CP_LEN_W-1:0] cp);
		return (cp > CP_MAX) ? CP_MAX : cp;
	endfunction

endpackage

// ===== rtl/cpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpi_ctrl
// Load/playout sequencer: counts samples in, then paces the prefix and
// rotated symbol out of the datapath one read at a time.
// ----------------------------------------------------------------------------
module cpi_ctrl #(
	parameter int SYMBOL_LEN = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          more_in_packet,
	input  logic [cpi_pkg::CP_LEN_W-1:0]  cp_len,
	input  logic                          burst_tag_enable,
	input  cpi_pkg::cpi_status_t          status,
	output cpi_pkg::cpi_cmd_t             cmd,
	output logic [$clog2(SYMBOL_LEN)-1:0] wr_idx
);

	localparam int IDX_W = $clog2(SYMBOL_LEN);
	localparam int CNT_W = $clog2(int'(cpi_pkg::CP_MAX) + SYMBOL_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_LEN - 1);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic             state_q;
	logic [IDX_W-1:0] fill_q;
	logic [CNT_W-1:0] remain_q;
	logic             last_sym_q;
	logic             accept;
	logic [CNT_W-1:0] total_m1;

	assign in_ready = (state_q == ST_LOAD);
	assign accept   = in_valid && in_ready;
	assign wr_idx   = fill_q;
	assign total_m1 = CNT_W'(cpi_pkg::cp_sat(cp_len)) + CNT_W'(SYMBOL_LEN - 1);

	always_comb begin
		cmd       = '0;
		cmd.wr    = accept;
		cmd.start = accept && (fill_q == LAST_IDX);
		cmd.rd    = (state_q == ST_EMIT) && status.can_issue;
		cmd.last  = (remain_q == '0);
		cmd.burst = burst_tag_enable && !(cmd.last && last_sym_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			fill_q     <= '0;
			remain_q   <= '0;
			last_sym_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (fill_q == LAST_IDX) begin
							fill_q     <= '0;
							remain_q   <= total_m1;
							last_sym_q <= !more_in_packet;
							state_q    <= ST_EMIT;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (cmd.rd) begin
						if (cmd.last) begin
							state_q <= ST_LOAD;
						end else begin
							remain_q <= remain_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== rtl/cpi_datapath.sv =====
// ----------------------------------------------------------------------------
// cpi_datapath
// Sample memory, playout address generator, read stage and output register.
// ----------------------------------------------------------------------------
module cpi_datapath #(
	parameter int SYMBOL_LEN = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpi_pkg::in_item_t             in_data,
	input  logic [cpi_pkg::CP_LEN_W-1:0]  cp_len,
	input  cpi_pkg::cpi_cmd_t             cmd,
	input  logic [$clog2(SYMBOL_LEN)-1:0] wr_idx,
	output cpi_pkg::cpi_status_t          status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cpi_pkg::out_item_t            out_data
);

	localparam int IDX_W = $clog2(SYMBOL_LEN);
	localparam int CP_Q  = int'(cpi_pkg::CP_MAX) / SYMBOL_LEN;
	localparam logic [5:0] N6 = 6'(SYMBOL_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOL_LEN - 1);

	logic [2*cpi_pkg::SAMPLE_W-1:0] mem [SYMBOL_LEN];

	logic [IDX_W-1:0]               rd_idx_q;
	logic [IDX_W-1:0]               start_idx;
	logic                           valid_s1;
	logic [2*cpi_pkg::SAMPLE_W-1:0] data_s1;
	logic                           burst_s1;
	logic                           end_s1;
	logic                           out_valid_q;
	cpi_pkg::out_item_t             out_q;
	logic                           adv;

	// Start index = -(cp + shift) mod SYMBOL_LEN, with the shift saturated.
	always_comb begin
		logic [5:0] cpm;
		logic [5:0] sh;
		logic [5:0] sum;
		logic [5:0] base;
		cpm = cpi_pkg::cp_sat(cp_len);
		for (int k = 0; k < CP_Q; k++) begin
			if (cpm >= N6) begin
				cpm = cpm - N6;
			end
		end
		sh = {1'b0, in_data.delay_shift};
		if (sh >= N6) begin
			sh = N6 - 6'd1;
		end
		sum  = cpm + sh;
		base = (sum >= N6) ? (sum - N6) : sum;
		start_idx = (base == 6'd0) ? '0 : IDX_W'(N6 - base);
	end

	assign adv              = valid_s1 && (!out_valid_q || out_ready);
	assign status.can_issue = !valid_s1 || adv;
	assign out_valid        = out_valid_q;
	assign out_data         = out_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_idx] <= {in_data.in_q, in_data.in_i};
		end
		if (cmd.rd) begin
			data_s1  <= mem[rd_idx_q];
			burst_s1 <= cmd.burst;
			end_s1   <= cmd.last;
		end
		if (cmd.start) begin
			rd_idx_q <= start_idx;
		end else if (cmd.rd) begin
			rd_idx_q <= (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
		end
		if (adv) begin
			out_q.out_i      <= data_s1[cpi_pkg::SAMPLE_W-1:0];
			out_q.out_q      <= data_s1[2*cpi_pkg::SAMPLE_W-1:cpi_pkg::SAMPLE_W];
			out_q.burst_flag <= burst_s1;
			out_q.symbol_end <= end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.rd) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/ofdm_cyclic_prefix_inserter.sv =====
// Load: one input sample per cycle, SYMBOL_LEN samples per symbol.
// Playout: starts once the final sample is accepted, each read passing through
// the read stage and output register; one result per cycle unless stalled,
// cp_len + SYMBOL_LEN results in all (prefix capped at 32). The single sample
// memory is filled, then read out before the next load.
// Reset (arst_n low, asynchronous) clears control state and valid flags and restores the configuration registers.
// ----------------------------------------------------------------------------
// ofdm_cyclic_prefix_inserter
// Collects one OFDM symbol, then emits it rotated by a cyclic delay with
// the cyclic prefix prepended.
// ----------------------------------------------------------------------------
module ofdm_cyclic_prefix_inserter #(
	parameter int SYMBOL_LEN = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input request channel: one complex sample per request.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  cpi_pkg::in_item_t               in_data,
	// Output request channel: one prefixed, rotated sample per request.
	output logic                            out_valid,
	input  logic                            out_ready,
	output cpi_pkg::out_item_t              out_data,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [cpi_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Registers written through the configuration port. Writes to indexes
	// beyond the register list are dropped.
	logic [cpi_pkg::CP_LEN_W-1:0] cp_len_q;
	logic                         burst_tag_enable_q;

	// The controller and datapath talk only through these two structs plus
	// the write address of the sample memory.
	cpi_pkg::cpi_cmd_t            cmd;
	cpi_pkg::cpi_status_t         status;
	logic [$clog2(SYMBOL_LEN)-1:0] wr_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_len_q           <= cpi_pkg::CP_LEN_RESET;
			burst_tag_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				cpi_pkg::REG_CP_LEN: begin
					cp_len_q <= cfg_data;
				end
				cpi_pkg::REG_BURST_TAG_ENABLE: begin
					burst_tag_enable_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// The controller counts incoming samples and, once a symbol is complete,
	// issues one memory read per cycle that the read stage can accept. It
	// latches the packet flag from the final sample for the burst tag.
	cpi_ctrl #(
		.SYMBOL_LEN(SYMBOL_LEN)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.more_in_packet   (in_data.more_in_packet),
		.cp_len           (cp_len_q),
		.burst_tag_enable (burst_tag_enable_q),
		.status           (status),
		.cmd              (cmd),
		.wr_idx           (wr_idx)
	);

	// The datapath holds the sample memory. On the final sample it computes
	// where playout begins, so that the read address simply walks forward
	// modulo SYMBOL_LEN. Reads pass through a registered read stage and an
	// output register, which lets a stalled output keep its result while
	// the next one waits in the read stage.
	cpi_datapath #(
		.SYMBOL_LEN(SYMBOL_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cp_len    (cp_len_q),
		.cmd       (cmd),
		.wr_idx    (wr_idx),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/cpi_checker.sv =====
// ----------------------------------------------------------------------------
// cpi_checker
// Port-level checks for the cyclic prefix inserter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpi_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input cpi_pkg::out_item_t              out_data,
	input logic                            cfg_we,
	input logic [cpi_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input logic [cpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Shadow of the burst tag enable register, as written on the port.
	logic burst_shadow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_shadow_q <= 1'b0;
		end else if (cfg_we && (cfg_idx == cpi_pkg::REG_BURST_TAG_ENABLE)) begin
			burst_shadow_q <= cfg_data[0];
		end
	end

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed while stalled")
	`ASSERT_IMPL(a_ready_drop, $fell(in_ready), $past(in_valid), "input ready dropped without an accepted sample")
	`ASSERT_IMPL(a_burst_mid, out_valid && !out_data.symbol_end, out_data.burst_flag == burst_shadow_q, "burst flag wrong inside a symbol")

endmodule

bind ofdm_cyclic_prefix_inserter cpi_checker u_cpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_idx   (cfg_idx),
	.cfg_data  (cfg_data)
);
